// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl (included by crpf_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk outside reset
`define CRPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define CRPF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/crpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package crpf_pkg;

  localparam int F            = 16;
  localparam int DIV_STEPS    = 32 + F;
  localparam int CORDIC_STEPS = 20;
  localparam int MAC_STEPS    = 5;

  localparam int WW  = 21;  // spline weight width
  localparam int AW  = 40;  // accumulator width
  localparam int RW  = 39;  // spline result width
  localparam int CXW = 42;  // cordic vector width
  localparam int CZW = 25;  // cordic angle width

  localparam logic signed [CZW-1:0] PI_Q20 = 25'sd3294199;
  localparam logic signed [CZW-1:0] PI_Q13 = 25'sd25736;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_LOOK   = 1'b1;

  typedef struct packed {
    logic       start;
    logic       append;
    logic       eval_load;
    logic       div_step;
    logic       clamp;
    logic       sq;
    logic       cube;
    logic       wgt;
    logic       rd;
    logic       mac;
    logic       store;
    logic       cor_init;
    logic       cor_step;
    logic       load_out;
    logic [1:0] sel;
    logic [2:0] k;
    logic [4:0] iter;
  } cmd_t;

  function automatic logic signed [CZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [CZW-1:0] v;
    unique case (i)
      5'd0:    v = 25'sd823550;
      5'd1:    v = 25'sd486170;
      5'd2:    v = 25'sd256879;
      5'd3:    v = 25'sd130396;
      5'd4:    v = 25'sd65451;
      5'd5:    v = 25'sd32757;
      5'd6:    v = 25'sd16383;
      5'd7:    v = 25'sd8192;
      5'd8:    v = 25'sd4096;
      5'd9:    v = 25'sd2048;
      5'd10:   v = 25'sd1024;
      5'd11:   v = 25'sd512;
      5'd12:   v = 25'sd256;
      5'd13:   v = 25'sd128;
      5'd14:   v = 25'sd64;
      5'd15:   v = 25'sd32;
      5'd16:   v = 25'sd16;
      5'd17:   v = 25'sd8;
      5'd18:   v = 25'sd4;
      5'd19:   v = 25'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crpf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module crpf_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_moved,
  input  wire logic        count_zero,
  output crpf_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DIV   = 12'b0000_0000_0010,
    S_CLAMP = 12'b0000_0000_0100,
    S_SQ    = 12'b0000_0000_1000,
    S_CUBE  = 12'b0000_0001_0000,
    S_WGT   = 12'b0000_0010_0000,
    S_MAC   = 12'b0000_0100_0000,
    S_STORE = 12'b0000_1000_0000,
    S_CINIT = 12'b0001_0000_0000,
    S_CORD  = 12'b0010_0000_0000,
    S_FINAL = 12'b0100_0000_0000,
    S_EMPTY = 12'b1000_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_moved_r, out_moved_nxt;
  logic       slot_free;
  logic       emit;
  logic       emit_moved;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_moved = out_moved_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    emit       = 1'b0;
    emit_moved = 1'b0;
    cmd        = '0;
    cmd.sel    = sel_r;
    cmd.k      = cnt_r[2:0];
    cmd.iter   = cnt_r[4:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (crpf_pkg::op_t'(in_op))
            crpf_pkg::OP_START:  cmd.start  = 1'b1;
            crpf_pkg::OP_APPEND: cmd.append = 1'b1;
            crpf_pkg::OP_EVAL: begin
              if (count_zero) begin
                state_nxt = S_EMPTY;
              end else begin
                cmd.eval_load = 1'b1;
                cnt_nxt       = '0;
                state_nxt     = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(crpf_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        sel_nxt   = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        state_nxt = S_WGT;
      end
      S_WGT: begin
        cmd.wgt   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.rd  = (cnt_r < 6'd4);
        cmd.mac = (cnt_r != 6'd0);
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(crpf_pkg::MAC_STEPS - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (sel_r == 2'd2) begin
          state_nxt = S_CINIT;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_CINIT: begin
        cmd.cor_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_CORD;
      end
      S_CORD: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(crpf_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          emit         = 1'b1;
          emit_moved   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_moved_nxt = out_moved_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_moved_nxt = emit_moved;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      out_moved_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      out_moved_r <= out_moved_nxt;
    end
  end

  `CRPF_ASSERT(a_div_to_clamp, (state_r == S_DIV && cnt_r == 6'(crpf_pkg::DIV_STEPS - 1)) |=> (state_r == S_CLAMP), "divider did not finish after its last step")
  `CRPF_NEVER(a_load_when_full, cmd.load_out && !slot_free, "result loaded over a waiting beat")
  `CRPF_ASSERT(a_moved_hold, (out_valid_r && out_stall) |=> $stable(out_moved_r), "moved flag changed under stall")

endmodule
`default_nettype wire

// ===== rtl/core/crpf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module crpf_dp #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  crpf_pkg::cmd_t          cmd,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_point_z,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    count_zero,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_heading
);

  localparam int F    = crpf_pkg::F;
  localparam int IDXW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int TW   = IDXW + F;
  localparam int DW   = crpf_pkg::DIV_STEPS;
  localparam int WW   = crpf_pkg::WW;
  localparam int AW   = crpf_pkg::AW;
  localparam int RW   = crpf_pkg::RW;
  localparam int CXW  = crpf_pkg::CXW;
  localparam int CZW  = crpf_pkg::CZW;

  // configuration and path state
  logic [15:0]   period_r, look_r;
  logic [CW-1:0] count_r;
  logic [31:0]   start_r;

  // divider
  logic [DW-1:0] dvd_r;
  logic [15:0]   rem_r;
  logic [15:0]   period_eff;
  logic [16:0]   trial;
  logic          qbit;

  // curve parameters
  logic [TW-1:0] t_r, tp_r, tn_r, tsel, tmax, t_cl;
  logic [TW:0]   t_plus, off_e;
  logic [IDXW-1:0] last_idx;

  // spline
  logic [15:0]            s, s2_r, s3_r;
  logic [31:0]            sq_prod, cube_prod;
  logic signed [WW-1:0]   w_r [4];
  logic signed [WW-1:0]   se, s2e, s3e, w_sel;
  logic signed [AW-1:0]   acc_r [3];
  logic signed [36:0]     prod [3];
  logic signed [RW-1:0]   res_r [3][3];
  logic signed [IDXW+1:0] idx_raw, last_s;
  logic [IDXW-1:0]        raddr;
  logic [47:0]            rdata;
  logic [2:0]             km1;

  // cordic
  logic signed [CXW-1:0] x_r, y_r, xs, ys, dx, dz;
  logic signed [CZW-1:0] z_r, zr, zc;
  logic                  zero_r;

  // output rounding
  logic signed [RW:0]    px, pz;
  logic [15:0]           head_nxt;

  assign count_zero = (count_r == '0);
  assign period_eff = (period_r == 16'd0) ? 16'd1 : period_r;
  assign trial      = {rem_r, dvd_r[DW-1]};
  assign qbit       = (trial >= {1'b0, period_eff});

  assign last_idx = IDXW'(count_r - CW'(1));
  assign tmax     = {last_idx, {F{1'b0}}};
  assign t_cl     = (dvd_r > DW'(tmax)) ? tmax : dvd_r[TW-1:0];
  assign off_e    = (TW+1)'(look_r);
  assign t_plus   = {1'b0, t_cl} + off_e;

  always_comb begin
    unique case (cmd.sel)
      2'd0:    tsel = tp_r;
      2'd1:    tsel = t_r;
      default: tsel = tn_r;
    endcase
  end

  assign s         = tsel[F-1:0];
  assign sq_prod   = s * s;
  assign cube_prod = s2_r * s;
  assign se        = $signed(WW'(s));
  assign s2e       = $signed(WW'(s2_r));
  assign s3e       = $signed(WW'(s3_r));

  // neighbour index clamped to the stored range
  assign idx_raw = $signed({2'b00, tsel[TW-1:F]}) - (IDXW+2)'(1) + $signed({{(IDXW-1){1'b0}}, cmd.k});
  assign last_s  = $signed({2'b00, last_idx});
  always_comb begin
    priority if (idx_raw < 0) begin
      raddr = '0;
    end else if (idx_raw > last_s) begin
      raddr = last_idx;
    end else begin
      raddr = idx_raw[IDXW-1:0];
    end
  end

  assign km1   = cmd.k - 3'd1;
  assign w_sel = w_r[km1[1:0]];
  assign prod[0] = w_sel * $signed(rdata[47:32]);
  assign prod[1] = w_sel * $signed(rdata[31:16]);
  assign prod[2] = w_sel * $signed(rdata[15:0]);

  assign dx = CXW'(res_r[2][0]) - CXW'(res_r[0][0]);
  assign dz = CXW'(res_r[2][2]) - CXW'(res_r[0][2]);
  assign xs = x_r >>> cmd.iter;
  assign ys = y_r >>> cmd.iter;

  assign zr = (z_r + CZW'(64)) >>> 7;
  always_comb begin
    priority if (zr > crpf_pkg::PI_Q13) begin
      zc = crpf_pkg::PI_Q13;
    end else if (zr < -crpf_pkg::PI_Q13) begin
      zc = -crpf_pkg::PI_Q13;
    end else begin
      zc = zr;
    end
  end
  assign head_nxt = zero_r ? 16'd0 : 16'(-zc);

  assign px = (RW+1)'(res_r[1][0]) + (RW+1)'(32768);
  assign pz = (RW+1)'(res_r[1][2]) + (RW+1)'(32768);

  function automatic logic signed [31:0] sat32(input logic signed [RW:0] v);
    logic signed [31:0] r;
    priority if (v > (RW+1)'(32'sh7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (v < -(RW+1)'(33'sd2147483648)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  crpf_ram #(
    .WIDTH (48),
    .DEPTH (MAX_POINTS)
  ) u_path (
    .clk   (clk),
    .we    (cmd.append && (count_r < CW'(MAX_POINTS))),
    .waddr (count_r[IDXW-1:0]),
    .wdata ({in_point_x, in_point_y, in_point_z}),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= 16'd1600;
      look_r      <= 16'd21627;
      count_r     <= '0;
      start_r     <= '0;
      out_pos_x   <= '0;
      out_pos_y   <= '0;
      out_pos_z   <= '0;
      out_heading <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == crpf_pkg::CFG_PERIOD) begin
          period_r <= cfg_data;
        end else begin
          look_r <= cfg_data;
        end
      end
      if (cmd.start) begin
        count_r <= '0;
        start_r <= in_now_ms;
      end else if (cmd.append && (count_r < CW'(MAX_POINTS))) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_pos_x   <= sat32(px);
        out_pos_y   <= sat32((RW+1)'(res_r[1][1]));
        out_pos_z   <= sat32(pz);
        out_heading <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      dvd_r <= {in_now_ms - start_r, {F{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? 16'(trial - {1'b0, period_eff}) : trial[15:0];
      dvd_r <= {dvd_r[DW-2:0], qbit};
    end
    if (cmd.clamp) begin
      t_r  <= t_cl;
      tp_r <= ({1'b0, t_cl} > off_e) ? TW'({1'b0, t_cl} - off_e) : '0;
      tn_r <= (t_plus < {1'b0, tmax}) ? t_plus[TW-1:0] : tmax;
    end
    if (cmd.sq) begin
      s2_r <= sq_prod[31:16];
    end
    if (cmd.cube) begin
      s3_r <= cube_prod[31:16];
    end
    if (cmd.wgt) begin
      w_r[0] <= -s3e + (s2e <<< 1) - se;
      w_r[1] <= (s3e <<< 1) + s3e - (s2e <<< 2) - s2e + WW'(2 << F);
      w_r[2] <= -(s3e <<< 1) - s3e + (s2e <<< 2) + se;
      w_r[3] <= s3e - s2e;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end
    if (cmd.mac) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + AW'(prod[c]);
      end
    end
    if (cmd.store) begin
      for (int c = 0; c < 3; c++) begin
        res_r[cmd.sel][c] <= acc_r[c][AW-1:1];
      end
    end
    if (cmd.cor_init) begin
      zero_r <= (dx == '0) && (dz == '0);
      if (dx < 0) begin
        x_r <= -dx;
        y_r <= -dz;
        z_r <= (dz >= 0) ? crpf_pkg::PI_Q20 : -crpf_pkg::PI_Q20;
      end else begin
        x_r <= dx;
        y_r <= dz;
        z_r <= '0;
      end
    end else if (cmd.cor_step) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + crpf_pkg::atan_q20(cmd.iter);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - crpf_pkg::atan_q20(cmd.iter);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/catmull_rom_path_follower.sv =====
`timescale 1ns / 1ps
`default_nettype none
// catmull-rom path follower
// input channel (in_valid / in_stall): one beat carries op, now_ms and a point.
//   op start clears the path and latches now_ms, op append stores one point
//   (dropped once the path is full), op evaluate returns one result beat,
//   op code 3 is ignored. start and append do not stall the input.
// result channel (out_valid / out_stall): moved, pos_x/y/z (q.16) and heading
//   (q3.13 radians). an evaluate on an empty path returns the held values with
//   moved low, by way of the empty state once the output slot is free.
// evaluate steps: the bit-serial time divider, the three spline evaluations through
//   the shared point memory (one read per neighbour), the cordic loop, plus
//   control steps. the input stalls until an evaluate has finished, so a new
//   beat is taken only once the previous evaluate is through.
// a finished result waits in the output register; the block still takes start
//   and append beats meanwhile, and a following evaluate waits for the slot.
// cfg port: cfg_index 0 period in ms, 1 look offset; always ready, write only
//   while idle.
// reset (synchronous, rst_n low) empties the path, zeroes the held position and
//   heading and restores the register defaults; no clearing pass is needed.
module catmull_rom_path_follower #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_moved,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_heading,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  crpf_pkg::cmd_t cmd;
  logic           count_zero;

  // registers are plain flops, so every cfg beat is taken at once
  assign cfg_ready = 1'b1;

  crpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_moved  (out_moved),
    .count_zero (count_zero),
    .cmd        (cmd)
  );

  crpf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_now_ms   (in_now_ms),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .count_zero  (count_zero),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .out_heading (out_heading)
  );

endmodule
`default_nettype wire

// ===== bench/tb_catmull_rom_path_follower.sv =====
`timescale 1ns / 1ps
module tb_catmull_rom_path_follower;

  // path geometry and fixed-point constants
  localparam int NPTS    = 64;
  localparam int NSTEP   = 20;
  localparam longint PI20 = 3294199;
  localparam longint PI13 = 25736;
  localparam int EVAL_LAT = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = crpf_pkg::OP_NONE;
  logic [31:0]        in_now_ms = '0;
  logic signed [15:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_moved;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_heading;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = crpf_pkg::CFG_PERIOD;
  logic [15:0]        cfg_data = '0;

  catmull_rom_path_follower u_top (.*);

  // one result beat
  typedef struct packed {
    logic               moved;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] hd;
  } pose_t;

  // one directed stimulus row; chk set means the typed-in pose must also match
  typedef struct {
    crpf_pkg::op_t      op;
    logic [31:0]        now;
    logic signed [15:0] x, y, z;
    bit                 chk;
    pose_t              pose;
  } row_t;

  // predictor state
  logic signed [15:0] path_pts [NPTS][3];
  int unsigned        path_len;
  logic [31:0]        t_start;
  logic signed [31:0] hold_pos [3];
  logic signed [15:0] hold_hd;
  logic [15:0]        period_reg, look_reg;

  pose_t pose_q [$];
  int    n_err = 0;
  bit    quiet = 1'b0;   // no-idle stretch flag

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_tab(int i);
    longint t [NSTEP] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // catmull-rom evaluation at parameter t (q.16), clamped neighbours
  function automatic void curve_at(longint unsigned t, output longint r [3]);
    longint base, s, s2, s3, sum;
    longint w [4];
    int idx [4];
    base = longint'(t >> 16);
    s  = longint'(t & 64'hFFFF);
    s2 = (s * s) >>> 16;
    s3 = (s2 * s) >>> 16;
    w[0] = -s3 + 2 * s2 - s;
    w[1] = 3 * s3 - 5 * s2 + 2 * 65536;
    w[2] = -3 * s3 + 4 * s2 + s;
    w[3] = s3 - s2;
    for (int k = 0; k < 4; k++) begin
      longint i;
      i = base - 1 + k;
      if (i < 0) i = 0;
      if (i > longint'(path_len) - 1) i = path_len - 1;
      idx[k] = int'(i);
    end
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int k = 0; k < 4; k++) sum += w[k] * longint'(path_pts[idx[k]][c]);
      r[c] = fshr(sum, 1);
    end
  endfunction

  // cordic arctangent, q.13 rounded half up and clamped
  function automatic longint heading_of(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI20 : -PI20;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEP; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_tab(i);
      end else begin
        x -= ys; y += xs; z -= atan_tab(i);
      end
    end
    z = fshr(z + 64, 7);
    if (z > PI13) z = PI13;
    if (z < -PI13) z = -PI13;
    return z;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // advance the predictor by one accepted beat, queueing any pose
  function automatic void follow_beat(logic [1:0] op, logic [31:0] now,
                                      logic signed [15:0] x, y, z);
    longint unsigned per, t, tmax, tp, tn;
    longint pp [3], pc [3], pn [3];
    pose_t p;
    case (op)
      crpf_pkg::OP_START: begin
        path_len = 0;
        t_start = now;
      end
      crpf_pkg::OP_APPEND: begin
        if (path_len < NPTS) begin
          path_pts[path_len][0] = x;
          path_pts[path_len][1] = y;
          path_pts[path_len][2] = z;
          path_len++;
        end
      end
      crpf_pkg::OP_EVAL: begin
        if (path_len == 0) begin
          p.moved = 1'b0;
        end else begin
          per  = (period_reg == 0) ? 1 : period_reg;
          t    = ({32'd0, now - t_start} << 16) / per;
          tmax = longint'(path_len - 1) << 16;
          if (t > tmax) t = tmax;
          tp = (t > look_reg) ? t - look_reg : 0;
          tn = (t + look_reg < tmax) ? t + look_reg : tmax;
          curve_at(tp, pp);
          curve_at(t, pc);
          curve_at(tn, pn);
          hold_hd = 16'(-heading_of(pn[2] - pp[2], pn[0] - pp[0]));
          hold_pos[0] = sat32(pc[0] + 32768);
          hold_pos[1] = sat32(pc[1]);
          hold_pos[2] = sat32(pc[2] + 32768);
          p.moved = 1'b1;
        end
        p.px = hold_pos[0];
        p.py = hold_pos[1];
        p.pz = hold_pos[2];
        p.hd = hold_hd;
        pose_q.push_back(p);
      end
      default: ;
    endcase
  endfunction

  function automatic void report(string what, longint exp_v, longint got_v);
    n_err++;
    if (n_err <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endfunction

  // result side: random stall, compare against oldest expected pose
  always @(negedge clk) begin
    if (rst_n) out_stall <= !quiet && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        report("unexpected result beat", 0, 1);
      end else begin
        pose_t e;
        e = pose_q.pop_front();
        if (out_moved !== e.moved) report("moved", e.moved, out_moved);
        if (out_pos_x !== e.px) report("pos_x", e.px, out_pos_x);
        if (out_pos_y !== e.py) report("pos_y", e.py, out_pos_y);
        if (out_pos_z !== e.pz) report("pos_z", e.pz, out_pos_z);
        if (out_heading !== e.hd) report("heading", e.hd, out_heading);
      end
    end
  end

  // send one beat, idling first at random; predictor updated on acceptance
  // valid stays high on return, the next beat or drain takes it down
  task automatic send_beat(crpf_pkg::op_t op, logic [31:0] now,
                           logic signed [15:0] x, y, z);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_now_ms  <= now;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    follow_beat(op, now, x, y, z);
    @(negedge clk);
  endtask

  // waits for the result store to drain, then for the block to settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (EVAL_LAT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == crpf_pkg::CFG_PERIOD) period_reg = val;
    else look_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom);
      default: return $signed(16'($urandom_range(40))) - 16'sd20;
    endcase
  endfunction

  // directed rows; the empty evaluates and the one-point evaluate have their poses typed in
  row_t rows [] = '{
    '{crpf_pkg::OP_EVAL,   32'd5,          0,      0,      0,      1, '{1'b0, 0, 0, 0, 0}},
    '{crpf_pkg::OP_NONE,   32'hFFFFFFFF,  -1,     -1,     -1,      0, '0},
    '{crpf_pkg::OP_START,  32'd1000,       0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd1000,       0,      0,      0,      1, '{1'b0, 0, 0, 0, 0}},
    '{crpf_pkg::OP_APPEND, 32'd0,          3,     -4,      5,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd9999,       0,      0,      0,      1,
      '{1'b1, 32'sd229376, -32'sd262144, 32'sd360448, 16'sd0}},
    '{crpf_pkg::OP_APPEND, 32'd0,      32767,  32767,  32767,      0, '0},
    '{crpf_pkg::OP_APPEND, 32'd0,     -32768, -32768, -32768,      0, '0},
    '{crpf_pkg::OP_APPEND, 32'd0,         10,      0,     -7,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd1000,       0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd1800,       0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd3400,       0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd999,        0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'hFFFFFFFF,   0,      0,      0,      0, '0},
    '{crpf_pkg::OP_START,  32'hFFFFFFF0,   0,      0,      0,      0, '0},
    '{crpf_pkg::OP_APPEND, 32'd0,          0,      0,      0,      0, '0},
    '{crpf_pkg::OP_APPEND, 32'd0,          0,      9,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd20,         0,      0,      0,      0, '0},
    '{crpf_pkg::OP_EVAL,   32'd0,          0,      0,      0,      0, '0}
  };

  initial begin
    int seen;
    for (int i = 0; i < NPTS; i++) path_pts[i] = '{0, 0, 0};
    path_len = 0;
    t_start = 0;
    hold_pos = '{0, 0, 0};
    hold_hd = 0;
    period_reg = 16'd1600;
    look_reg = 16'd21627;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings; typed poses are checked up front
    foreach (rows[i]) begin
      int before_n;
      before_n = pose_q.size();
      follow_beat(rows[i].op, rows[i].now, rows[i].x, rows[i].y, rows[i].z);
      if (rows[i].chk && pose_q.size() > before_n && pose_q[$] !== rows[i].pose)
        report("typed pose row", i, 0);
    end
    // rebuild predictor from reset and replay through the block
    path_len = 0; t_start = 0; hold_pos = '{0, 0, 0}; hold_hd = 0;
    pose_q.delete();
    foreach (rows[i]) begin
      int before_n;
      before_n = pose_q.size();
      send_beat(rows[i].op, rows[i].now, rows[i].x, rows[i].y, rows[i].z);
      if (rows[i].chk && pose_q.size() > before_n)
        pose_q[$] = rows[i].pose;
    end
    // path overflow: more than capacity appends then evaluate at the end
    send_beat(crpf_pkg::OP_START, 32'd0, 0, 0, 0);
    for (int i = 0; i < NPTS + 3; i++)
      send_beat(crpf_pkg::OP_APPEND, 32'd0, 16'(i), 16'(-i), 16'(2 * i));
    send_beat(crpf_pkg::OP_EVAL, 32'hFFFFFFFF, 0, 0, 0);
    drain();

    // random phases across register settings, extremes included
    seen = 0;
    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] per, lk;
      case (ph)
        0: begin per = 16'd0;     lk = 16'd0;     end
        1: begin per = 16'd1;     lk = 16'hFFFF;  end
        2: begin per = 16'hFFFF;  lk = 16'd21627; end
        3: begin per = 16'd1600;  lk = 16'd1;     end
        default: begin per = 16'($urandom_range(1, 4000)); lk = 16'($urandom); end
      endcase
      write_reg(crpf_pkg::CFG_PERIOD, per);
      write_reg(crpf_pkg::CFG_LOOK, lk);
      quiet = (ph == 5);
      for (int n = 0; n < 160; n++) begin
        int r;
        logic [31:0] base_t;
        r = $urandom_range(99);
        if (r < 6) begin
          // build a fresh path with random content
          base_t = $urandom;
          send_beat(crpf_pkg::OP_START, base_t, rnd_coord(), rnd_coord(), rnd_coord());
          repeat ($urandom_range(1, 6)) send_beat(crpf_pkg::OP_APPEND, $urandom,
                                                 rnd_coord(), rnd_coord(), rnd_coord());
        end else if (r < 20) begin
          send_beat(crpf_pkg::OP_APPEND, $urandom, rnd_coord(), rnd_coord(), rnd_coord());
        end else if (r < 23) begin
          send_beat(crpf_pkg::OP_NONE, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
        end else begin
          logic [31:0] dt;
          case ($urandom_range(3))
            0:       dt = $urandom;
            1:       dt = $urandom_range(0, 20) * per;
            default: dt = $urandom_range(0, 8 * ((per == 0) ? 1 : per));
          endcase
          send_beat(crpf_pkg::OP_EVAL, t_start + dt, 16'($urandom), 16'($urandom),
                    16'($urandom));
          seen++;
        end
      end
      drain();
    end
    quiet = 1'b0;
    drain();

    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard run limit
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/crpf_pkg.sv
rtl/core/crpf_ram.sv
rtl/core/crpf_ctrl.sv
rtl/core/crpf_dp.sv
rtl/core/catmull_rom_path_follower.sv
bench/tb_catmull_rom_path_follower.sv
